// ===== rtl/skvt_pkg.sv =====
// ---------------------------------------------------------------------------
// skvt_pkg: shared definitions for the sorted key/value table
// Default sizes, request codes and status codes used by all table files.
// ---------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

  // default sizes
  localparam int CAPACITY_DEF   = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int REQ_TYPE_BITS = 3;
  localparam int STATUS_BITS   = 2;

  // request codes
  localparam logic [REQ_TYPE_BITS-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_TYPE_BITS-1:0] REQ_FIND   = 3'd1;
  localparam logic [REQ_TYPE_BITS-1:0] REQ_ERASE  = 3'd2;
  localparam logic [REQ_TYPE_BITS-1:0] REQ_RANGE  = 3'd3;
  localparam logic [REQ_TYPE_BITS-1:0] REQ_CLEAR  = 3'd4;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EXISTS    = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/skvt_store.sv =====
// ---------------------------------------------------------------------------
// skvt_store: entry storage of the sorted key/value table
// Key and value arrays with one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module skvt_store
  import skvt_pkg::*;
#(
  parameter int DEPTH      = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IW        = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [IW-1:0]         wr_addr,
  input  wire logic [KEY_BITS-1:0]   wr_key,
  input  wire logic [VALUE_BITS-1:0] wr_value,
  input  wire logic [IW-1:0]         rd_addr,
  output logic      [KEY_BITS-1:0]   rd_key,
  output logic      [VALUE_BITS-1:0] rd_value
);

  logic [KEY_BITS-1:0]   key_mem   [DEPTH];
  logic [VALUE_BITS-1:0] value_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[wr_addr] <= wr_value;
    end
    rd_value <= value_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_key_value_table.sv =====
// ---------------------------------------------------------------------------
// sorted_key_value_table: table of unique keys kept in ascending order
// Insert, find, erase, range erase and clear over a sorted entry store.
// ---------------------------------------------------------------------------
// usage
//   input channel (in_*): one request per transfer; in_tuser holds the
//   request type, in_tdata the key, the range upper bound and the value.
//   output channel (out_*): exactly one result transfer per request with
//   status, found value, removed count and entry count.
//   a single compare unit walks the store one entry per cycle from entry 0
//   until it meets a key not below the search key; range erase continues
//   with the same unit up to the upper bound. entries are then moved one
//   per cycle through the store's single read and write port (up for an
//   insert, down to close a gap after an erase).
//   a request is accepted and searched; for range erase the bound is
//   searched as well; entries are moved when the table changes; then the
//   result is handed to the output register. in_tready is high only
//   between requests.
//   the finished result sits in an output register; a stalled receiver
//   holds it there, and the next request may be accepted meanwhile but its
//   result waits until the register is free.
//   reset empties the table (entry count zero) and drops any pending result;
//   the store itself is not cleared, entries are only read below the count.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table
  import skvt_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int CW        = $clog2(CAPACITY + 1),
  localparam int IN_W      = ((2 * KEY_BITS + VALUE_BITS) + 7) / 8 * 8,
  localparam int OUT_W     = ((STATUS_BITS + VALUE_BITS + 2 * CW) + 7) / 8 * 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // request channel
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // in_tdata: req_key, range_high, req_value (lowest first), zero padded
  input  wire logic [IN_W-1:0]          in_tdata,
  // in_tuser: req_type
  input  wire logic [REQ_TYPE_BITS-1:0] in_tuser,
  // result channel
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // out_tdata: status, found_value, removed_count, entry_count (lowest
  // first), zero padded
  output logic      [OUT_W-1:0]         out_tdata
);

  localparam int IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;  // find first key >= search key
  localparam logic [2:0] S_SCAN_END = 3'd2;  // range erase: find first key >= bound
  localparam logic [2:0] S_SHIFT_UP = 3'd3;  // open a slot for insert
  localparam logic [2:0] S_SHIFT_DN = 3'd4;  // close the gap after erase
  localparam logic [2:0] S_FIN      = 3'd5;  // hand result to output register

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic [CW-1:0]            src_r, src_nxt;
  logic [CW-1:0]            dst_r, dst_nxt;
  logic                     pend_r, pend_nxt;
  logic [REQ_TYPE_BITS-1:0] type_r, type_nxt;
  logic [KEY_BITS-1:0]      key_r, key_nxt;
  logic [KEY_BITS-1:0]      high_r, high_nxt;
  logic [VALUE_BITS-1:0]    val_r, val_nxt;
  logic [STATUS_BITS-1:0]   status_r, status_nxt;
  logic [VALUE_BITS-1:0]    found_r, found_nxt;
  logic [CW-1:0]            removed_r, removed_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]         out_tdata_r, out_tdata_nxt;

  // store ports
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_value;
  logic [CW-1:0]         rd_ptr;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;

  // shared compare unit
  logic [KEY_BITS-1:0] cmp_target;
  logic [CW-1:0]       cmp_idx;
  logic                cmp_valid;
  logic                cmp_lt;
  logic                cmp_eq;
  logic                hit;

  skvt_store #(
    .DEPTH      (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_value (wr_value),
    .rd_addr  (rd_ptr[IW-1:0]),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  // rd_key holds the entry at the scan index; it is valid below the count
  assign cmp_target = (state_r == S_SCAN_END) ? high_r : key_r;
  assign cmp_idx    = (state_r == S_SCAN_END) ? src_r : pos_r;
  assign cmp_valid  = cmp_idx < count_r;
  assign cmp_lt     = cmp_valid && (rd_key < cmp_target);
  assign cmp_eq     = cmp_valid && (rd_key == cmp_target);
  assign hit        = cmp_eq;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    pend_nxt       = pend_r;
    type_nxt       = type_r;
    key_nxt        = key_r;
    high_nxt       = high_r;
    val_nxt        = val_r;
    status_nxt     = status_r;
    found_nxt      = found_r;
    removed_nxt    = removed_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    wr_en          = 1'b0;
    wr_addr        = dst_r[IW-1:0];
    wr_key         = rd_key;
    wr_value       = rd_value;
    rd_ptr         = '0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // entry 0 is read ahead so the scan can start at once
        rd_ptr = '0;
        if (in_tvalid) begin
          type_nxt    = in_tuser;
          key_nxt     = in_tdata[KEY_BITS-1:0];
          high_nxt    = in_tdata[2*KEY_BITS-1:KEY_BITS];
          val_nxt     = in_tdata[2*KEY_BITS+VALUE_BITS-1:2*KEY_BITS];
          pos_nxt     = '0;
          status_nxt  = ST_DONE;
          found_nxt   = '0;
          removed_nxt = '0;
          case (in_tuser)
            REQ_INSERT, REQ_FIND, REQ_ERASE, REQ_RANGE: begin
              state_nxt = S_SCAN;
            end
            REQ_CLEAR: begin
              removed_nxt = count_r;
              count_nxt   = '0;
              state_nxt   = S_FIN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (cmp_lt) begin
          pos_nxt = pos_r + 1'b1;
          rd_ptr  = pos_r + 1'b1;
        end else begin
          // keep the entry at the stop position on the read port
          rd_ptr = pos_r;
          case (type_r)
            REQ_INSERT: begin
              if (hit) begin
                status_nxt = ST_EXISTS;
                state_nxt  = S_FIN;
              end else if (count_r == CAP_C) begin
                status_nxt = ST_FULL;
                state_nxt  = S_FIN;
              end else begin
                src_nxt   = count_r;
                pend_nxt  = 1'b0;
                state_nxt = S_SHIFT_UP;
              end
            end
            REQ_FIND: begin
              if (hit) begin
                found_nxt = rd_value;
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
              state_nxt = S_FIN;
            end
            REQ_ERASE: begin
              if (hit) begin
                src_nxt     = pos_r + 1'b1;
                dst_nxt     = pos_r;
                removed_nxt = CW'(1);
                pend_nxt    = 1'b0;
                state_nxt   = S_SHIFT_DN;
              end else begin
                status_nxt = ST_NOT_FOUND;
                state_nxt  = S_FIN;
              end
            end
            REQ_RANGE: begin
              src_nxt   = pos_r;
              state_nxt = S_SCAN_END;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_SCAN_END: begin
        if (cmp_lt) begin
          src_nxt = src_r + 1'b1;
          rd_ptr  = src_r + 1'b1;
        end else begin
          rd_ptr = src_r;
          if (src_r == pos_r) begin
            state_nxt = S_FIN;
          end else begin
            removed_nxt = src_r - pos_r;
            dst_nxt     = pos_r;
            pend_nxt    = 1'b0;
            state_nxt   = S_SHIFT_DN;
          end
        end
      end

      S_SHIFT_DN: begin
        // read ahead at src, write in the following cycle at dst
        rd_ptr = src_r;
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = dst_r[IW-1:0];
          dst_nxt = dst_r + 1'b1;
        end
        if (src_r < count_r) begin
          src_nxt  = src_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - removed_r;
            state_nxt = S_FIN;
          end
        end
      end

      S_SHIFT_UP: begin
        // walk down from the top, moving each entry one slot up
        rd_ptr = src_r - 1'b1;
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = dst_r[IW-1:0];
        end
        if (src_r > pos_r) begin
          src_nxt  = src_r - 1'b1;
          dst_nxt  = src_r;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            wr_en     = 1'b1;
            wr_addr   = pos_r[IW-1:0];
            wr_key    = key_r;
            wr_value  = val_r;
            count_nxt = count_r + 1'b1;
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_W'({count_r, removed_r, found_r, status_r});
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    type_r      <= type_nxt;
    key_r       <= key_nxt;
    high_r      <= high_nxt;
    val_r       <= val_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    removed_r   <= removed_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // entry count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  // a slot is only opened in a table that is not full
  a_no_shift_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_UP) |-> (count_r < CAP_C))
    else $error("insert shift in a full table");

  // the scan index never goes beyond the entry count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (pos_r <= count_r))
    else $error("scan beyond held entries");

  // while closing a gap the write side stays below the read side
  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_DN) |-> (dst_r < src_r))
    else $error("erase move overtakes its source");

  // one request at a time: an accepted request blocks the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input open while a request is in work");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: request/result check of the sorted key/value table
// Drives table requests over the input stream with random gaps and stalls
// the result stream at random. A scoreboard keeps its own sorted copy of the
// table, predicts one result per accepted request and compares every result
// transfer with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

import skvt_pkg::*;

// request as packed on in_tdata: req_key lowest, then range_high, req_value
typedef struct packed {
  logic [VALUE_BITS_DEF-1:0] req_value;
  logic [KEY_BITS_DEF-1:0]   range_high;
  logic [KEY_BITS_DEF-1:0]   req_key;
} table_request_t;

// result as packed on out_tdata: status lowest, zero padding on top
typedef struct packed {
  logic [3:0]                pad;
  logic [4:0]                entry_count;
  logic [4:0]                removed_count;
  logic [VALUE_BITS_DEF-1:0] found_value;
  logic [STATUS_BITS-1:0]    status;
} table_result_t;

class table_scoreboard;
  logic [KEY_BITS_DEF-1:0]   stored_keys[CAPACITY_DEF];
  logic [VALUE_BITS_DEF-1:0] stored_values[CAPACITY_DEF];
  int unsigned               held;
  table_result_t             expected_q[$];
  int unsigned               error_count;

  function new();
    held = 0;
    error_count = 0;
  endfunction

  // first slot whose key is not below the given key
  function int unsigned first_not_below(logic [KEY_BITS_DEF-1:0] key);
    int unsigned i;
    i = 0;
    while (i < held && stored_keys[i] < key) i++;
    return i;
  endfunction

  // remove slots [from, to) and close the gap
  function void drop_entries(int unsigned from, int unsigned to);
    int unsigned i;
    for (i = from; i + (to - from) < held; i++) begin
      stored_keys[i]   = stored_keys[i + (to - from)];
      stored_values[i] = stored_values[i + (to - from)];
    end
    held = held - (to - from);
  endfunction

  function void note_request(logic [REQ_TYPE_BITS-1:0] kind, table_request_t req);
    table_result_t res;
    int unsigned   pos;
    int unsigned   stop;
    int unsigned   removed;
    int unsigned   i;
    logic          hit;
    res = '0;
    res.status = ST_DONE;
    removed = 0;
    pos = first_not_below(req.req_key);
    hit = (pos < held) && (stored_keys[pos] == req.req_key);
    case (kind)
      REQ_INSERT: begin
        if (hit) begin
          res.status = ST_EXISTS;
        end else if (held >= CAPACITY_DEF) begin
          res.status = ST_FULL;
        end else begin
          for (i = held; i > pos; i--) begin
            stored_keys[i]   = stored_keys[i - 1];
            stored_values[i] = stored_values[i - 1];
          end
          stored_keys[pos]   = req.req_key;
          stored_values[pos] = req.req_value;
          held++;
        end
      end
      REQ_FIND: begin
        if (hit) res.found_value = stored_values[pos];
        else res.status = ST_NOT_FOUND;
      end
      REQ_ERASE: begin
        if (hit) begin
          drop_entries(pos, pos + 1);
          removed = 1;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      REQ_RANGE: begin
        stop = pos;
        while (stop < held && stored_keys[stop] < req.range_high) stop++;
        removed = stop - pos;
        drop_entries(pos, stop);
      end
      REQ_CLEAR: begin
        removed = held;
        held = 0;
      end
      default: begin
      end
    endcase
    res.removed_count = 5'(removed);
    res.entry_count   = 5'(held);
    expected_q.push_back(res);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task check_result(table_result_t got);
    table_result_t want;
    if (expected_q.size() == 0) begin
      report("unexpected result, status", 32'(got.status), 32'(ST_DONE));
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status)
      report("status", 32'(got.status), 32'(want.status));
    if (got.found_value !== want.found_value)
      report("found_value", got.found_value, want.found_value);
    if (got.removed_count !== want.removed_count)
      report("removed_count", 32'(got.removed_count), 32'(want.removed_count));
    if (got.entry_count !== want.entry_count)
      report("entry_count", 32'(got.entry_count), 32'(want.entry_count));
  endtask
endclass

module testbench;

  localparam int IN_W  = ((2 * KEY_BITS_DEF + VALUE_BITS_DEF) + 7) / 8 * 8;
  localparam int OUT_W = ((STATUS_BITS + VALUE_BITS_DEF + 10) + 7) / 8 * 8;

  localparam int IDLE_PERCENT   = 34;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1720;
  localparam int POOL_SIZE      = 24;

  // highest request code, unused by the table
  localparam logic [REQ_TYPE_BITS-1:0] REQ_UNUSED_TOP = 3'd7;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata   = '0;
  logic [REQ_TYPE_BITS-1:0] in_tuser   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_W-1:0]         out_tdata;

  // high while neither side inserts idle cycles
  logic                     steady = 1'b0;
  int unsigned              quiet_cycles = 0;
  logic [KEY_BITS_DEF-1:0]  key_pool[POOL_SIZE];

  table_scoreboard book = new();

  sorted_key_value_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // result side: random stalls, check every transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_result(table_result_t'(out_tdata));
    out_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // watchdog: too long without any transfer on either side ends the run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one request transfer; valid stays high into the next call unless it idles
  task automatic send_request(logic [REQ_TYPE_BITS-1:0] kind, logic [31:0] key,
                              logic [31:0] high, logic [31:0] value);
    table_request_t req;
    req = '{req_value: value, range_high: high, req_key: key};
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= req;
    do @(posedge clk); while (!in_tready);
    book.note_request(kind, req);
  endtask

  // stop sending until every predicted result has arrived
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    while (book.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned              sent;
    int unsigned              roll;
    logic [REQ_TYPE_BITS-1:0] kind;
    logic [31:0]              key;
    logic [31:0]              high;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: empty table corners
    send_request(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
    send_request(REQ_ERASE, 32'h1234_5678, 32'h0, 32'h0);
    send_request(REQ_UNUSED_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // key extremes with value extremes, then a duplicate
    send_request(REQ_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_request(REQ_INSERT, 32'h0, 32'h0, 32'h5555_5555);
    // fill the table to capacity
    for (int i = 1; i <= CAPACITY_DEF - 2; i++)
      send_request(REQ_INSERT, 32'h1111_1111 * i, $urandom, $urandom);
    // full table: new key refused, duplicate still reported as existing
    send_request(REQ_INSERT, 32'h5, 32'h0, 32'hA5A5_A5A5);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0, 32'hA5A5_A5A5);
    send_request(REQ_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_request(REQ_FIND, 32'h5, 32'h0, 32'h0);
    // range with low bound above high bound removes nothing
    send_request(REQ_RANGE, 32'h8888_8888, 32'h2222_2222, 32'h0);
    // erase the top key, then a range that reaches the last entry
    send_request(REQ_ERASE, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_request(REQ_RANGE, 32'hCCCC_CCCC, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
    hold_until_drained();

    // random part: keys mostly from a small pool so that hits are common
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 250 == 0) begin
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
      end
      steady <= (sent >= 700 && sent < 1000);
      if (sent == 1300) hold_until_drained();

      roll = $urandom_range(99);
      if (roll < 42) kind = REQ_INSERT;
      else if (roll < 62) kind = REQ_FIND;
      else if (roll < 77) kind = REQ_ERASE;
      else if (roll < 89) kind = REQ_RANGE;
      else if (roll < 92) kind = REQ_CLEAR;
      else kind = 3'($urandom_range(REQ_CLEAR + 1, REQ_UNUSED_TOP));

      key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      roll = $urandom_range(99);
      if (roll < 40) high = key_pool[$urandom_range(POOL_SIZE - 1)];
      else if (roll < 70) high = key + $urandom_range(32'h3000_0000);
      else if (roll < 85) high = $urandom;
      else high = 32'hFFFF_FFFF;

      send_request(kind, key, high, $urandom);
      sent++;
    end
    steady <= 1'b0;

    hold_until_drained();
    repeat (40) @(posedge clk);
    if (book.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sorted_key_value_table.f =====
rtl/skvt_pkg.sv
rtl/skvt_store.sv
rtl/sorted_key_value_table.sv
test/testbench.sv
